// ===== src/pcw_pkg.sv =====
package pcw_pkg;

  localparam int unsigned MaxDepthDefault = 16;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [63:0] Low32 = 64'h0000_0000_ffff_ffff;

  typedef enum logic [0:0] {
    REG_WIDE_POINTERS     = 1'b0,
    REG_REQUIRE_CANONICAL = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_RESOLVED      = 3'd0,
    ST_BUSY          = 3'd1,
    ST_OVERFLOW      = 3'd2,
    ST_NONCANON_ADDR = 3'd3,
    ST_READ_FAIL     = 3'd4,
    ST_NULL          = 3'd5,
    ST_NONCANON_PTR  = 3'd6,
    ST_DEPTH         = 3'd7
  } status_e;

  typedef struct packed {
    logic wide_pointers;
    logic require_canonical;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [63:0]        base_address;
    logic               read_ok;
    logic [63:0]        read_data;
    logic signed [63:0] offset;
    logic               ends_chain;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] address;
    logic [4:0]  steps_done;
    logic [63:0] last_pointer;
  } result_t;

endpackage

// ===== src/pcw_cfg.sv =====
module pcw_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcw_pkg::AddrW-1:0] paddr,
  input  logic [pcw_pkg::DataW-1:0] pwdata,
  output logic [pcw_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output pcw_pkg::cfg_t             cfg_o
);

  pcw_pkg::cfg_t    cfg_q, cfg_d;
  pcw_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = pcw_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        pcw_pkg::REG_WIDE_POINTERS:     cfg_d.wide_pointers     = pwdata[0];
        pcw_pkg::REG_REQUIRE_CANONICAL: cfg_d.require_canonical = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{wide_pointers: 1'b1, require_canonical: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pcw_pkg::REG_WIDE_POINTERS:     prdata[0] = cfg_q.wide_pointers;
      pcw_pkg::REG_REQUIRE_CANONICAL: prdata[0] = cfg_q.require_canonical;
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/pcw_resolve.sv =====
module pcw_resolve #(
  parameter int unsigned MaxDepth = pcw_pkg::MaxDepthDefault,
  localparam int unsigned CntW    = $clog2(MaxDepth + 1)
) (
  input  pcw_pkg::cfg_t    cfg_i,
  input  pcw_pkg::item_t   item_i,
  input  logic [63:0]      cursor_i,
  input  logic [CntW-1:0]  count_i,
  input  pcw_pkg::status_e status_i,
  output logic [63:0]      cursor_o,
  output logic [CntW-1:0]  count_o,
  output pcw_pkg::status_e status_o,
  output pcw_pkg::result_t result_o
);

  function automatic logic canon(input logic wide, input logic [63:0] a);
    if (wide) begin
      return (a[63:47] == '0) || (a[63:47] == '1);
    end
    return a[63:32] == '0;
  endfunction

  logic        wide, req;
  logic [64:0] span;
  logic [63:0] span_end;
  logic [63:0] pointer;
  logic [64:0] psum;
  logic [63:0] next_addr;
  logic        span_ovf, add_ovf;
  logic [63:0] ptr_out;

  assign wide = cfg_i.wide_pointers;
  assign req  = cfg_i.require_canonical;

  // last byte of the pointer at the cursor
  assign span     = {1'b0, cursor_i} + (wide ? 65'd7 : 65'd3);
  assign span_end = span[63:0];
  assign span_ovf = span[64] | (~wide & (span[63:32] != '0));

  assign pointer   = wide ? item_i.read_data : (item_i.read_data & pcw_pkg::Low32);
  // carry out means a wrap for a positive offset and no borrow for a negative one
  assign psum      = {1'b0, pointer} + {1'b0, item_i.offset};
  assign next_addr = psum[63:0];
  assign add_ovf   = (psum[64] ^ item_i.offset[63]) | (~wide & (next_addr[63:32] != '0));

  always_comb begin
    cursor_o = cursor_i;
    count_o  = count_i;
    status_o = status_i;
    ptr_out  = '0;
    if (item_i.op == pcw_pkg::OP_START) begin
      cursor_o = item_i.base_address;
      count_o  = '0;
      if ((~wide & (item_i.base_address[63:32] != '0)) ||
          (req & ~canon(wide, item_i.base_address))) begin
        status_o = pcw_pkg::ST_NONCANON_ADDR;
      end else begin
        status_o = item_i.ends_chain ? pcw_pkg::ST_RESOLVED : pcw_pkg::ST_BUSY;
      end
    end else if (status_i == pcw_pkg::ST_BUSY) begin
      if (count_i >= CntW'(MaxDepth)) begin
        status_o = pcw_pkg::ST_DEPTH;
      end else if (span_ovf) begin
        status_o = pcw_pkg::ST_OVERFLOW;
      end else if (req & (~canon(wide, cursor_i) | ~canon(wide, span_end))) begin
        status_o = pcw_pkg::ST_NONCANON_ADDR;
      end else if (!item_i.read_ok) begin
        status_o = pcw_pkg::ST_READ_FAIL;
      end else if (pointer == '0) begin
        status_o = pcw_pkg::ST_NULL;
      end else begin
        ptr_out = pointer;
        if (req & ~canon(wide, pointer)) begin
          status_o = pcw_pkg::ST_NONCANON_PTR;
        end else if (add_ovf) begin
          status_o = pcw_pkg::ST_OVERFLOW;
        end else if (req & ~canon(wide, next_addr)) begin
          status_o = pcw_pkg::ST_NONCANON_ADDR;
        end else begin
          cursor_o = next_addr;
          count_o  = count_i + 1'b1;
          status_o = item_i.ends_chain ? pcw_pkg::ST_RESOLVED : pcw_pkg::ST_BUSY;
        end
      end
    end
  end

  assign result_o.status       = status_o;
  assign result_o.address      = cursor_o;
  assign result_o.steps_done   = 5'(count_o);
  assign result_o.last_pointer = ptr_out;

endmodule

// ===== src/pointer_chain_walker.sv =====
// path: input register, then result register; throughput: one item per cycle
// while the output is not stalled; the chain state (cursor, depth, status) is
// updated in the same cycle the result register loads, so the next item sees it
// reset: cursor 0, depth 0, status resolved, 8-byte pointers, canonical checks on
module pointer_chain_walker #(
  parameter int unsigned MaxDepth = pcw_pkg::MaxDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pcw_pkg::item_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pcw_pkg::result_t          out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcw_pkg::AddrW-1:0] paddr,
  input  logic [pcw_pkg::DataW-1:0] pwdata,
  output logic [pcw_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned CntW = $clog2(MaxDepth + 1);

  pcw_pkg::cfg_t    cfg;
  logic             in_valid_q;
  pcw_pkg::item_t   in_item_q;
  logic             out_valid_q;
  pcw_pkg::result_t out_data_q;
  logic [63:0]      cursor_q, cursor_d;
  logic [CntW-1:0]  count_q, count_d;
  pcw_pkg::status_e status_q, status_d;
  pcw_pkg::result_t result;
  logic             advance, accept;

  pcw_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  pcw_resolve #(
    .MaxDepth (MaxDepth)
  ) u_resolve (
    .cfg_i    (cfg),
    .item_i   (in_item_q),
    .cursor_i (cursor_q),
    .count_i  (count_q),
    .status_i (status_q),
    .cursor_o (cursor_d),
    .count_o  (count_d),
    .status_o (status_d),
    .result_o (result)
  );

  // the input register moves on when the result register is empty or drains
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cursor_q    <= '0;
      count_q     <= '0;
      status_q    <= pcw_pkg::ST_RESOLVED;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cursor_q    <= cursor_d;
        count_q     <= count_d;
        status_q    <= status_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
